// ----- sv/waveform_tone_sample_top_macros.svh -----
// assertion macros shared by the tone sample rtl
`ifndef WAVEFORM_TONE_SAMPLE_TOP_MACROS_SVH
`define WAVEFORM_TONE_SAMPLE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication on clk, off while in reset
`define WTS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk, off while in reset
`define WTS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define WTS_ASSERT_NOW(name, ante, cons, msg)
`define WTS_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

// ----- sv/wts_pkg.sv -----
`timescale 1ns / 1ps

package wts_pkg;

  localparam int SEL_W    = 3;
  localparam int VEL_W    = 7;
  localparam int DAC_W    = 11;
  localparam int DAC_MAX  = 1270;

  localparam logic [SEL_W-1:0] WAVE_SQUARE   = 3'd0;
  localparam logic [SEL_W-1:0] WAVE_PULSE    = 3'd1;
  localparam logic [SEL_W-1:0] WAVE_SAW      = 3'd2;
  localparam logic [SEL_W-1:0] WAVE_TRIANGLE = 3'd3;
  localparam logic [SEL_W-1:0] WAVE_SILENT   = 3'd4;

  // what rides along the modulo chain with each beat
  typedef struct packed {
    logic [SEL_W-1:0] wave;
    logic [VEL_W-1:0] vel;
  } wts_side_t;

endpackage

// ----- sv/wts_cell.sv -----
`timescale 1ns / 1ps

`include "waveform_tone_sample_top_macros.svh"

module wts_cell
  import wts_pkg::*;
#(
  parameter int REM_W  = 16,
  parameter int DVD_W  = 32,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [REM_W-1:0]  in_rem,
  input  logic [DVD_W-1:0]  in_dvd,
  input  logic [REM_W-1:0]  in_dvs,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [REM_W-1:0]  out_rem,
  output logic [DVD_W-1:0]  out_dvd,
  output logic [REM_W-1:0]  out_dvs,
  output logic [SIDE_W-1:0] out_side
);

  logic              vld_r;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [REM_W-1:0]  dvs_r;
  logic [SIDE_W-1:0] side_r;

  logic [REM_W:0] trial;
  logic [REM_W:0] diff;
  logic           ge;

  // one restoring step: shift in the next dividend bit, quotient bit enters at the bottom
  always_comb begin
    trial   = {in_rem, in_dvd[DVD_W-1]};
    diff    = trial - {1'b0, in_dvs};
    ge      = trial >= {1'b0, in_dvs};
    rem_nxt = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
    dvd_nxt = {in_dvd[DVD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dvd_r  <= dvd_nxt;
    dvs_r  <= in_dvs;
    side_r <= in_side;
  end

  assign out_vld  = vld_r;
  assign out_rem  = rem_r;
  assign out_dvd  = dvd_r;
  assign out_dvs  = dvs_r;
  assign out_side = side_r;

  `WTS_ASSERT_NEXT(a_vld_moves, in_vld, vld_r, "cell dropped a beat")
  `WTS_ASSERT_NEXT(a_no_ghost, !in_vld, !vld_r, "cell invented a beat")
  `WTS_ASSERT_NOW(a_rem_below_dvs, vld_r && (dvs_r != '0), rem_r < dvs_r,
                  "partial remainder not below divisor")

endmodule

// ----- sv/wts_shape.sv -----
`timescale 1ns / 1ps

module wts_shape
  import wts_pkg::*;
#(
  parameter int PB = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  logic [PB-1:0]    in_phase,
  input  logic [PB-1:0]    in_dvs,
  input  wts_side_t        in_side,
  output logic             out_vld,
  output logic [PB-1:0]    out_rem,
  output logic [DAC_W-1:0] out_dvd,
  output logic [PB-1:0]    out_dvs,
  output logic             out_zero
);

  logic             vld_a_r, vld_b_r;
  logic [DAC_W-1:0] amp_r, amp_nxt;
  logic [PB-1:0]    x_r, x_nxt;
  logic [PB-1:0]    dvs_a_r, dvs_b_r;
  logic             zero_a_r, zero_b_r;
  logic [PB+DAC_W-1:0] prod_r, prod_nxt;

  logic [PB:0]   two_c;
  logic [PB+1:0] four_c;
  logic [PB:0]   fall;
  logic          first_half;
  logic          first_quarter;

  always_comb begin
    amp_nxt       = {1'b0, in_side.vel, 3'b000} + {3'b000, in_side.vel, 1'b0};
    two_c         = {in_phase, 1'b0};
    four_c        = {in_phase, 2'b00};
    first_half    = two_c < {1'b0, in_dvs};
    first_quarter = four_c < {2'b00, in_dvs};
    fall          = {in_dvs, 1'b0} - two_c;
    // x is the fraction numerator over the period, never above the period
    unique case (in_side.wave)
      WAVE_SQUARE:   x_nxt = first_half ? in_dvs : '0;
      WAVE_PULSE:    x_nxt = first_quarter ? in_dvs : '0;
      WAVE_SAW:      x_nxt = in_phase;
      WAVE_TRIANGLE: x_nxt = first_half ? two_c[PB-1:0] : fall[PB-1:0];
      default:       x_nxt = '0;
    endcase
    prod_nxt = {{PB{1'b0}}, amp_r} * {{DAC_W{1'b0}}, x_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      vld_a_r <= in_vld;
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    amp_r    <= amp_nxt;
    x_r      <= x_nxt;
    dvs_a_r  <= in_dvs;
    zero_a_r <= in_dvs == '0;
    prod_r   <= prod_nxt;
    dvs_b_r  <= dvs_a_r;
    zero_b_r <= zero_a_r;
  end

  // quotient stays below 2^DAC_W, so the upper product bits start as a remainder below the period
  assign out_vld  = vld_b_r;
  assign out_rem  = prod_r[PB+DAC_W-1:DAC_W];
  assign out_dvd  = prod_r[DAC_W-1:0];
  assign out_dvs  = dvs_b_r;
  assign out_zero = zero_b_r;

endmodule

// ----- sv/waveform_tone_sample_top.sv -----
`timescale 1ns / 1ps

// Tone sample generator. Every cycle it can take a beat (tick count, period, velocity), and it
// later shows that beat's dac sample on out_dac_value with out_strobe high for exactly one
// cycle; busy stays low, so a new beat may start in every cycle and the receiver must take
// each sample as it appears. The pipeline is two chains of restoring-division cells with
// waveform shaping between them: one cell per tick count bit for the phase (tick count modulo
// period), two cells of waveform shaping and multiply, and one cell per output bit for the
// final divide by the period. The waveform select register is sampled when a beat starts.

`include "waveform_tone_sample_top_macros.svh"

module waveform_tone_sample_top
  import wts_pkg::*;
#(
  parameter int COUNT_BITS  = 32,
  parameter int PERIOD_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [COUNT_BITS-1:0]  in_tick_count,
  input  logic [PERIOD_BITS-1:0] in_period_ticks,
  input  logic [VEL_W-1:0]       in_velocity,
  input  logic                   cfg_wr_en,
  input  logic [SEL_W-1:0]       cfg_wr_data,
  output logic                   out_strobe,
  output logic [DAC_W-1:0]       out_dac_value
);

  localparam int SIDE_W = $bits(wts_side_t);
  localparam int LAT    = COUNT_BITS + 2 + DAC_W;

  logic [SEL_W-1:0] wave_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r <= WAVE_SQUARE;
    end else if (cfg_wr_en) begin
      wave_r <= cfg_wr_data;
    end
  end

  assign busy = 1'b0;

  // phase chain: tick count modulo period
  logic                   m_vld  [0:COUNT_BITS];
  logic [PERIOD_BITS-1:0] m_rem  [0:COUNT_BITS];
  logic [COUNT_BITS-1:0]  m_dvd  [0:COUNT_BITS];
  logic [PERIOD_BITS-1:0] m_dvs  [0:COUNT_BITS];
  logic [SIDE_W-1:0]      m_side [0:COUNT_BITS];
  wts_side_t              side_in;
  wts_side_t              side_out;

  always_comb begin
    side_in.wave = wave_r;
    side_in.vel  = in_velocity;
  end

  assign m_vld[0]  = start & ~busy;
  assign m_rem[0]  = '0;
  assign m_dvd[0]  = in_tick_count;
  assign m_dvs[0]  = in_period_ticks;
  assign m_side[0] = side_in;

  for (genvar i = 0; i < COUNT_BITS; i++) begin : g_mod
    wts_cell #(
      .REM_W  (PERIOD_BITS),
      .DVD_W  (COUNT_BITS),
      .SIDE_W (SIDE_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (m_vld[i]),
      .in_rem   (m_rem[i]),
      .in_dvd   (m_dvd[i]),
      .in_dvs   (m_dvs[i]),
      .in_side  (m_side[i]),
      .out_vld  (m_vld[i+1]),
      .out_rem  (m_rem[i+1]),
      .out_dvd  (m_dvd[i+1]),
      .out_dvs  (m_dvs[i+1]),
      .out_side (m_side[i+1])
    );
  end

  assign side_out = m_side[COUNT_BITS];

  // quotient chain: amplitude times fraction, divided by the period
  logic                   q_vld  [0:DAC_W];
  logic [PERIOD_BITS-1:0] q_rem  [0:DAC_W];
  logic [DAC_W-1:0]       q_dvd  [0:DAC_W];
  logic [PERIOD_BITS-1:0] q_dvs  [0:DAC_W];
  logic                   q_zero [0:DAC_W];

  wts_shape #(
    .PB (PERIOD_BITS)
  ) u_shape (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (m_vld[COUNT_BITS]),
    .in_phase (m_rem[COUNT_BITS]),
    .in_dvs   (m_dvs[COUNT_BITS]),
    .in_side  (side_out),
    .out_vld  (q_vld[0]),
    .out_rem  (q_rem[0]),
    .out_dvd  (q_dvd[0]),
    .out_dvs  (q_dvs[0]),
    .out_zero (q_zero[0])
  );

  for (genvar j = 0; j < DAC_W; j++) begin : g_quo
    wts_cell #(
      .REM_W  (PERIOD_BITS),
      .DVD_W  (DAC_W),
      .SIDE_W (1)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (q_vld[j]),
      .in_rem   (q_rem[j]),
      .in_dvd   (q_dvd[j]),
      .in_dvs   (q_dvs[j]),
      .in_side  (q_zero[j]),
      .out_vld  (q_vld[j+1]),
      .out_rem  (q_rem[j+1]),
      .out_dvd  (q_dvd[j+1]),
      .out_dvs  (q_dvs[j+1]),
      .out_side (q_zero[j+1])
    );
  end

  assign out_strobe    = q_vld[DAC_W];
  // zero period gives silence
  assign out_dac_value = q_zero[DAC_W] ? '0 : q_dvd[DAC_W];

  `WTS_ASSERT_NOW(a_dac_range, out_strobe, out_dac_value <= DAC_W'(DAC_MAX),
                  "sample above full scale")
  `WTS_ASSERT_NOW(a_zero_period,
                  out_strobe && $past(start && (in_period_ticks == '0), LAT),
                  out_dac_value == '0, "zero period gave a nonzero sample")
  `WTS_ASSERT_NOW(a_zero_velocity,
                  out_strobe && $past(start && (in_velocity == '0), LAT),
                  out_dac_value == '0, "zero velocity gave a nonzero sample")

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import wts_pkg::*;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 60;    // pipeline is COUNT_BITS + 13 deep
  localparam int PHASES        = 24;
  localparam int PHASE_BEATS   = 60;

  // a selector value past silent; all such values must read as zero
  localparam logic [SEL_W-1:0] WAVE_UNUSED = 3'd7;

  typedef struct packed {
    logic [SEL_W-1:0] wave;
    logic [31:0]      cnt;
    logic [15:0]      per;
    logic [VEL_W-1:0] vel;
    logic             known;
    logic [DAC_W-1:0] level;
  } tone_row_t;

  localparam int ROWS = 21;

  tone_row_t tone_rows [ROWS] = '{
    '{WAVE_SQUARE,   32'd0,        16'd1,     7'd127, 1'b1, 11'd1270},
    '{WAVE_SQUARE,   32'hFFFFFFFF, 16'd0,     7'd127, 1'b1, 11'd0},
    '{WAVE_SQUARE,   32'd4,        16'd10,    7'd1,   1'b1, 11'd10},
    '{WAVE_SQUARE,   32'd5,        16'd10,    7'd127, 1'b1, 11'd0},
    '{WAVE_SQUARE,   32'hFFFFFFFF, 16'hFFFF,  7'd0,   1'b1, 11'd0},
    '{WAVE_SQUARE,   32'h7FFFFFFF, 16'hFFFF,  7'd85,  1'b0, 11'd0},
    '{WAVE_PULSE,    32'd2,        16'd10,    7'd127, 1'b1, 11'd1270},
    '{WAVE_PULSE,    32'd3,        16'd10,    7'd127, 1'b1, 11'd0},
    '{WAVE_PULSE,    32'd0,        16'd0,     7'd127, 1'b1, 11'd0},
    '{WAVE_PULSE,    32'hFFFFFFFF, 16'd3,     7'd42,  1'b0, 11'd0},
    '{WAVE_SAW,      32'd65534,    16'hFFFF,  7'd127, 1'b0, 11'd0},
    '{WAVE_SAW,      32'd0,        16'hFFFF,  7'd127, 1'b1, 11'd0},
    '{WAVE_SAW,      32'd9,        16'd10,    7'd127, 1'b0, 11'd0},
    '{WAVE_SAW,      32'hFFFFFFFF, 16'd1,     7'd127, 1'b1, 11'd0},
    '{WAVE_TRIANGLE, 32'd5,        16'd10,    7'd127, 1'b1, 11'd1270},
    '{WAVE_TRIANGLE, 32'd0,        16'd10,    7'd127, 1'b1, 11'd0},
    '{WAVE_TRIANGLE, 32'd3,        16'd7,     7'd127, 1'b0, 11'd0},
    '{WAVE_TRIANGLE, 32'hFFFFFFFE, 16'hFFFF,  7'd127, 1'b0, 11'd0},
    '{WAVE_TRIANGLE, 32'd1,        16'd0,     7'd127, 1'b1, 11'd0},
    '{WAVE_SILENT,   32'd1,        16'd10,    7'd127, 1'b1, 11'd0},
    '{WAVE_UNUSED,   32'd0,        16'd10,    7'd127, 1'b1, 11'd0}
  };

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [31:0]      in_tick_count = '0;
  logic [15:0]      in_period_ticks = '0;
  logic [VEL_W-1:0] in_velocity = '0;
  logic             cfg_wr_en = 1'b0;
  logic [SEL_W-1:0] cfg_wr_data = '0;
  logic             out_strobe;
  logic [DAC_W-1:0] out_dac_value;

  logic [SEL_W-1:0] wave_sel = WAVE_SQUARE;
  logic [DAC_W-1:0] beat_level = '0;
  logic [DAC_W-1:0] due_level;
  logic [DAC_W-1:0] level_q [$];
  int               errors = 0;
  int               cycles = 0;

  waveform_tone_sample_top #(
    .COUNT_BITS(32),
    .PERIOD_BITS(16)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_tick_count(in_tick_count),
    .in_period_ticks(in_period_ticks),
    .in_velocity(in_velocity),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .out_strobe(out_strobe),
    .out_dac_value(out_dac_value)
  );

  always #10 clk = ~clk;

  function automatic logic [DAC_W-1:0] tone_level(input logic [SEL_W-1:0] wave,
                                                  input logic [31:0] cnt,
                                                  input logic [15:0] per,
                                                  input logic [VEL_W-1:0] vel);
    longint unsigned amp, p, ph, lvl;
    amp = 64'(vel);
    amp = amp * 64'd10;
    p = 64'(per);
    if (p == 0) return '0;
    ph = 64'(cnt);
    ph = ph % p;
    case (wave)
      WAVE_SQUARE:   lvl = (64'd2 * ph < p) ? amp : 64'd0;
      WAVE_PULSE:    lvl = (64'd4 * ph < p) ? amp : 64'd0;
      WAVE_SAW:      lvl = (amp * ph) / p;
      WAVE_TRIANGLE: lvl = (64'd2 * ph < p) ? (amp * 64'd2 * ph) / p
                                            : (amp * (64'd2 * p - 64'd2 * ph)) / p;
      default:       lvl = 64'd0;
    endcase
    return lvl[DAC_W-1:0];
  endfunction

  function automatic logic [15:0] pick_period();
    case ($urandom_range(0, 9))
      0: return 16'($urandom_range(0, 8));
      1: begin
        case ($urandom_range(0, 4))
          0: return 16'd0;
          1: return 16'd1;
          2: return 16'hFFFF;
          3: return 16'hFFFE;
          default: return 16'h8000;
        endcase
      end
      2, 3, 4, 5: return 16'($urandom_range(1, 300));
      default: return 16'($urandom);
    endcase
  endfunction

  // often lands on or next to the half, quarter and full period edges
  function automatic logic [31:0] pick_count(input logic [15:0] per);
    longint unsigned base, off, sum;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 2))
          0: return 32'd0;
          1: return 32'hFFFFFFFF;
          default: return 32'h80000000;
        endcase
      end
      default: begin
        base = 64'($urandom_range(0, 65535));
        base = base * 64'(per);
        case ($urandom_range(0, 3))
          0: off = 64'(per >> 1);
          1: off = 64'(per >> 2);
          2: off = 64'($urandom_range(0, 65535));
          default: off = 64'(per);
        endcase
        off = off + 64'($urandom_range(0, 2)) - 64'd1;
        sum = base + off;
        return sum[31:0];
      end
    endcase
  endfunction

  function automatic logic [VEL_W-1:0] pick_velocity();
    case ($urandom_range(0, 7))
      0: return 7'd0;
      1: return 7'd127;
      default: return VEL_W'($urandom);
    endcase
  endfunction

  task automatic send_tone(input logic [31:0] cnt, input logic [15:0] per,
                           input logic [VEL_W-1:0] vel, input logic known,
                           input logic [DAC_W-1:0] level);
    @(negedge clk);
    start <= 1'b1;
    in_tick_count <= cnt;
    in_period_ticks <= per;
    in_velocity <= vel;
    beat_level = known ? level : tone_level(wave_sel, cnt, per, vel);
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause_sender(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // checked at the falling edge, clear of the monitor's update
  task automatic wait_for_samples();
    @(negedge clk);
    start <= 1'b0;
    while (level_q.size() != 0) @(negedge clk);
  endtask

  task automatic set_waveform(input logic [SEL_W-1:0] sel);
    wait_for_samples();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= sel;
    wave_sel = sel;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) begin
        if (level_q.size() == 0) begin
          errors++;
          $display("%0t: dac_value with no beat pending: expected none, got %0d",
                   $time, out_dac_value);
        end else begin
          due_level = level_q.pop_front();
          if (out_dac_value !== due_level) begin
            errors++;
            $display("%0t: dac_value mismatch: expected %0d, got %0d",
                     $time, due_level, out_dac_value);
          end
        end
      end
      if (start && !busy) level_q.push_back(beat_level);
    end
  end

  initial begin : stimulus
    logic [SEL_W-1:0] sel;
    logic [15:0]      per;
    int               idle_pct;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    foreach (tone_rows[i]) begin
      if (tone_rows[i].wave != wave_sel) set_waveform(tone_rows[i].wave);
      send_tone(tone_rows[i].cnt, tone_rows[i].per, tone_rows[i].vel,
                tone_rows[i].known, tone_rows[i].level);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      // first pass walks every selector value, then a random mix
      if (ph < 8) sel = SEL_W'(ph);
      else if ($urandom_range(0, 5) == 0) sel = SEL_W'($urandom_range(5, 7));
      else sel = SEL_W'($urandom_range(0, 4));
      set_waveform(sel);
      case (ph % 3)
        0: idle_pct = 0;
        1: idle_pct = 62;
        default: idle_pct = 35;
      endcase
      for (int n = 0; n < PHASE_BEATS; n++) begin
        while ($urandom_range(0, 99) < idle_pct) pause_sender(1);
        if (ph == 4 && n == PHASE_BEATS / 2) wait_for_samples();
        per = pick_period();
        send_tone(pick_count(per), per, pick_velocity(), 1'b0, '0);
      end
    end

    wait_for_samples();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
